// ----- rtl/tmtw_pkg.sv -----
package tmtw_pkg;

    // Fixed field widths
    localparam int KIND_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int POS_W   = 11;
    localparam int COLOR_W = 8;
    localparam int CELL_W  = 16;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_PUT    = 2'd0,
        KIND_READ   = 2'd1,
        KIND_SETCUR = 2'd2,
        KIND_CLEAR  = 2'd3
    } t_kind;

    // Put flavors, chosen from the character at accept
    typedef enum logic [1:0] {
        PUT_CHAR    = 2'd0,
        PUT_NEWLINE = 2'd1,
        PUT_TAB     = 2'd2
    } t_put;

    // Special characters
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    // Attribute after reset and the blank cell the screen comes up with
    localparam logic [COLOR_W-1:0] RESET_COLOR = 8'd3;
    localparam logic [CELL_W-1:0]  RESET_CELL  = {RESET_COLOR, CH_SPACE};

endpackage

// ----- rtl/tmtw_in_if.sv -----
interface tmtw_in_if;
    logic                         valid;
    logic                         ready;
    logic [tmtw_pkg::KIND_W-1:0]  kind;
    logic [tmtw_pkg::CHAR_W-1:0]  char_code;
    logic [tmtw_pkg::POS_W-1:0]   position;

    modport source (output valid, output kind, output char_code, output position,
                    input ready);
    modport sink   (input valid, input kind, input char_code, input position,
                    output ready);
endinterface

// ----- rtl/tmtw_out_if.sv -----
interface tmtw_out_if;
    logic                         valid;
    logic                         ready;
    logic [tmtw_pkg::CELL_W-1:0]  cell_data;
    logic [tmtw_pkg::POS_W-1:0]   cursor_now;
    logic                         scrolled;

    modport source (output valid, output cell_data, output cursor_now, output scrolled,
                    input ready);
    modport sink   (input valid, input cell_data, input cursor_now, input scrolled,
                    output ready);
endinterface

// ----- rtl/text_mode_terminal_writer.sv -----
// Text console with a COLUMNS x ROWS screen of 16-bit cells (attribute byte over
// character byte) held in a single-port-write RAM, plus a cursor. One item is
// worked at a time and the next is taken once its result is in the output
// register. A printable character writes one cell, a newline moves the cursor
// to the next row start, a tab writes spaces up to the next tab stop, a read
// fetches one cell, a set cursor takes column and tab phase from a reciprocal
// multiply and a subtract, and a clear blanks every cell. Any put that runs past
// the last cell adds a scroll, paced by the one RAM write port (one cell copied
// per cycle). After reset a clearing pass writes blank cells before the first
// item is taken; the color register can be written during it.
module text_mode_terminal_writer #(
    parameter int COLUMNS  = 80,
    parameter int ROWS     = 25,
    parameter int TAB_STOP = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [tmtw_pkg::COLOR_W-1:0]   i_cfg_data,
    tmtw_in_if.sink                        i_in,
    tmtw_out_if.source                     o_out
);

    import tmtw_pkg::*;

    localparam int CELLS   = COLUMNS * ROWS;
    localparam int AW      = $clog2(CELLS);
    localparam int CW      = AW + 1;
    localparam int LRS     = (ROWS - 1) * COLUMNS;
    localparam int CLW     = $clog2(COLUMNS);
    localparam int TPW     = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam int LRS_TPH = LRS % TAB_STOP;

    typedef enum logic [8:0] {
        S_INIT   = 9'b000000001,
        S_IDLE   = 9'b000000010,
        S_STEP   = 9'b000000100,
        S_SCROLL = 9'b000001000,
        S_FILL   = 9'b000010000,
        S_READ   = 9'b000100000,
        S_MOD    = 9'b001000000,
        S_DONE   = 9'b010000000,
        S_SPARE  = 9'b100000000
    } t_state;

    t_state              r_state;
    logic [COLOR_W-1:0]  r_color;
    logic [CW-1:0]       r_cur;
    logic [CLW-1:0]      r_col;
    logic [TPW-1:0]      r_tph;
    t_put                r_put;
    logic [CHAR_W-1:0]   r_wchar;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_dst;
    logic                r_rdv;
    logic                r_scr;
    logic [CELL_W-1:0]   r_cell;

    logic                r_ovalid;
    logic [CELL_W-1:0]   r_ocell;
    logic [POS_W-1:0]    r_ocur;
    logic                r_oscr;

    logic                w_accept;
    logic [AW-1:0]       w_pos;
    logic [CW-1:0]       n_cur;
    logic [CLW-1:0]      n_col;
    logic [TPW-1:0]      n_tph;
    logic                w_step_end;
    logic                w_at_end;
    logic                w_out_free;

    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [CELL_W-1:0]   w_wdata;
    logic [AW-1:0]       w_raddr;
    logic [CELL_W-1:0]   w_rdata;

    logic                w_mod_start;
    logic                w_mod_done;
    logic [CLW-1:0]      w_mod_col;
    logic [TPW-1:0]      w_mod_tph;

    assign w_accept   = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == S_IDLE);
    assign w_out_free = !r_ovalid || o_out.ready;

    // Position saturated to the last cell
    assign w_pos = (32'(i_in.position) >= 32'(CELLS)) ? AW'(CELLS - 1) : AW'(i_in.position);

    // Cursor advance by one cell, with column and tab phase kept alongside
    always_comb begin
        n_cur      = r_cur + 1'b1;
        n_col      = (r_col == CLW'(COLUMNS - 1)) ? '0 : r_col + 1'b1;
        n_tph      = (r_tph == TPW'(TAB_STOP - 1)) ? '0 : r_tph + 1'b1;
        w_at_end   = (n_cur == CW'(CELLS));
        w_step_end = (r_put == PUT_CHAR)
                  || ((r_put == PUT_NEWLINE) && (n_col == '0))
                  || ((r_put == PUT_TAB) && (n_tph == '0));
    end

    // RAM port steering
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_dst[AW-1:0];
        w_wdata = {r_color, CH_SPACE};
        w_raddr = w_pos;
        case (r_state)
            S_INIT: begin
                w_we    = 1'b1;
                w_wdata = RESET_CELL;
            end
            S_STEP: begin
                w_we    = (r_put != PUT_NEWLINE);
                w_waddr = r_cur[AW-1:0];
                w_wdata = {r_color, r_wchar};
            end
            S_SCROLL: begin
                w_we    = r_rdv;
                w_wdata = w_rdata;
                w_raddr = r_idx[AW-1:0];
            end
            S_FILL: begin
                w_we = 1'b1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    assign w_mod_start = w_accept && (t_kind'(i_in.kind) == KIND_SETCUR);

    tmtw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    tmtw_mod_unit #(
        .AW       (AW),
        .COLUMNS  (COLUMNS),
        .TAB_STOP (TAB_STOP)
    ) u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_value (w_pos),
        .o_done  (w_mod_done),
        .o_col   (w_mod_col),
        .o_tph   (w_mod_tph)
    );

    // Color register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color <= RESET_COLOR;
        end else if (i_cfg_we) begin
            r_color <= i_cfg_data;
        end
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cur   <= '0;
            r_col   <= '0;
            r_tph   <= '0;
            r_dst   <= '0;
            r_idx   <= '0;
            r_rdv   <= 1'b0;
            r_scr   <= 1'b0;
            r_put   <= PUT_CHAR;
        end else begin
            case (r_state)
                S_INIT: begin
                    r_dst <= r_dst + 1'b1;
                    if (r_dst == CW'(CELLS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_scr  <= 1'b0;
                        r_cell <= '0;
                        case (t_kind'(i_in.kind))
                            KIND_PUT: begin
                                if (i_in.char_code == CH_NEWLINE) begin
                                    r_put <= PUT_NEWLINE;
                                end else if (i_in.char_code == CH_TAB) begin
                                    r_put <= PUT_TAB;
                                end else begin
                                    r_put <= PUT_CHAR;
                                end
                                r_wchar <= (i_in.char_code == CH_TAB) ? CH_SPACE
                                                                      : i_in.char_code;
                                r_state <= S_STEP;
                            end
                            KIND_READ: begin
                                r_state <= S_READ;
                            end
                            KIND_SETCUR: begin
                                r_cur   <= CW'(w_pos);
                                r_state <= S_MOD;
                            end
                            KIND_CLEAR: begin
                                r_dst   <= '0;
                                r_state <= S_FILL;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_STEP: begin
                    // One cell per cycle; a run past the end starts the scroll
                    if (w_at_end) begin
                        r_cur   <= CW'(LRS);
                        r_col   <= '0;
                        r_tph   <= TPW'(LRS_TPH);
                        r_scr   <= 1'b1;
                        r_idx   <= CW'(COLUMNS);
                        r_dst   <= '0;
                        r_rdv   <= 1'b0;
                        r_state <= S_SCROLL;
                    end else begin
                        r_cur <= n_cur;
                        r_col <= n_col;
                        r_tph <= n_tph;
                        if (w_step_end) begin
                            r_state <= S_DONE;
                        end
                    end
                end
                S_SCROLL: begin
                    // Read one row ahead, write back the cycle after
                    if (r_idx != CW'(CELLS)) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    r_rdv <= (r_idx != CW'(CELLS));
                    if (r_rdv) begin
                        r_dst <= r_dst + 1'b1;
                    end
                    if ((r_idx == CW'(CELLS)) && !r_rdv) begin
                        r_state <= S_FILL;
                    end
                end
                S_FILL: begin
                    r_dst <= r_dst + 1'b1;
                    if (r_dst == CW'(CELLS - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_READ: begin
                    r_cell  <= w_rdata;
                    r_state <= S_DONE;
                end
                S_MOD: begin
                    if (w_mod_done) begin
                        r_col   <= w_mod_col;
                        r_tph   <= w_mod_tph;
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if ((r_state == S_DONE) && w_out_free) begin
            r_ovalid <= 1'b1;
            r_ocell  <= r_cell;
            r_ocur   <= POS_W'(r_cur);
            r_oscr   <= r_scr;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_out.valid      = r_ovalid;
    assign o_out.cell_data  = r_ocell;
    assign o_out.cursor_now = r_ocur;
    assign o_out.scrolled   = r_oscr;

endmodule

// ----- rtl/tmtw_ram.sv -----
module tmtw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tmtw_mod_unit.sv -----
module tmtw_mod_unit #(
    parameter int AW       = 11,
    parameter int COLUMNS  = 80,
    parameter int TAB_STOP = 4
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_start,
    input  logic [AW-1:0]                                  i_value,
    output logic                                           o_done,
    output logic [$clog2(COLUMNS)-1:0]                     o_col,
    output logic [((TAB_STOP > 1) ? $clog2(TAB_STOP) : 1)-1:0] o_tph
);

    localparam int CLW = $clog2(COLUMNS);
    localparam int TPW = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    // Reciprocal scale: exact quotients for any AW-bit value, divisors up to 256
    localparam int SH  = AW + 9;
    localparam int RW  = SH + 1;
    localparam int PW  = AW + RW;
    localparam int MW  = 2 * AW;
    localparam logic [RW-1:0] REC_COL =
        RW'(((64'd1 << SH) + 64'(COLUMNS - 1)) / 64'(COLUMNS));
    localparam logic [RW-1:0] REC_TAB =
        RW'(((64'd1 << SH) + 64'(TAB_STOP - 1)) / 64'(TAB_STOP));

    logic           r_s1;
    logic           r_s2;
    logic           r_done;
    logic [AW-1:0]  r_val;
    logic [AW-1:0]  r_qc;
    logic [AW-1:0]  r_qt;
    logic [CLW-1:0] r_rc;
    logic [TPW-1:0] r_rt;

    logic [PW-1:0]  w_pc;
    logic [PW-1:0]  w_pt;
    logic [MW-1:0]  w_mc;
    logic [MW-1:0]  w_mt;
    logic [AW-1:0]  w_dc;
    logic [AW-1:0]  w_dt;

    // Quotient by reciprocal multiply, remainder by multiply-back and subtract
    always_comb begin
        w_pc = PW'(r_val) * PW'(REC_COL);
        w_pt = PW'(r_val) * PW'(REC_TAB);
        w_mc = MW'(r_qc) * MW'(COLUMNS);
        w_mt = MW'(r_qt) * MW'(TAB_STOP);
        w_dc = r_val - w_mc[AW-1:0];
        w_dt = r_val - w_mt[AW-1:0];
    end

    // Stage control: capture, quotient, remainder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1   <= 1'b0;
            r_s2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_s1   <= i_start;
            r_s2   <= r_s1;
            r_done <= r_s2;
        end
    end

    // Data path
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
        end
        if (r_s1) begin
            r_qc <= w_pc[SH +: AW];
            r_qt <= w_pt[SH +: AW];
        end
        if (r_s2) begin
            r_rc <= w_dc[CLW-1:0];
            r_rt <= w_dt[TPW-1:0];
        end
    end

    assign o_done = r_done;
    assign o_col  = r_rc;
    assign o_tph  = r_rt;

endmodule
